@@ sv/pli_pkg.sv @@
// Shared types and codes for the positional list unit.
// Depends on nothing; used by pli_cell and positional_list_insert_delete_unit.
`default_nettype none

package pli_pkg;

	localparam int DEFAULT_LIST_DEPTH = 16;
	localparam int VALUE_W = 32;
	localparam int POS_W = 5;
	localparam int LEN_W = 5;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_BAD_POS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [POS_W-1:0] position;
		logic signed [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [VALUE_W-1:0] entry_value;
		logic has_value;
		logic [LEN_W-1:0] list_length;
		logic last;
	} out_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		logic [POS_W-1:0] pos;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/pli_cell.sv @@
// One storage cell of the list chain: holds one entry and takes a new word from
// the command or a neighbor on insert, delete or rotate. Depends on pli_pkg.
`default_nettype none

module pli_cell #(
	parameter int INDEX = 0
) (
	input wire logic clk,
	input wire pli_pkg::cell_cmd_t cmd,
	input wire logic signed [pli_pkg::VALUE_W-1:0] up_value,
	input wire logic signed [pli_pkg::VALUE_W-1:0] down_value,
	output logic signed [pli_pkg::VALUE_W-1:0] value
);

	logic signed [pli_pkg::VALUE_W-1:0] value_q;
	logic signed [pli_pkg::VALUE_W-1:0] value_d;
	int pos;

	always_comb begin
		pos = int'(cmd.pos);
		value_d = value_q;
		unique case (cmd.op)
			pli_pkg::OP_INSERT: begin
				// load at the position, push later entries toward the tail
				if (INDEX + 1 == pos) begin
					value_d = cmd.value;
				end else if (INDEX + 1 > pos) begin
					value_d = up_value;
				end
			end
			pli_pkg::OP_DELETE: begin
				if (INDEX + 1 >= pos) begin
					value_d = down_value;
				end
			end
			pli_pkg::OP_ROTATE: value_d = down_value;
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

`default_nettype wire

@@ sv/positional_list_insert_delete_unit.sv @@
// Positional list unit: a chain of LIST_DEPTH cells plus the control that
// checks positions and sequences read out. Depends on pli_pkg and pli_cell.
//
// Usage: drive item and raise start; the word is taken at a clock edge with
// start high and busy low. Every item gives its result words on result with
// result_valid high for one cycle each; the receiver cannot stall them.
// Insert and delete: the cells from the position on shift in parallel at the
// accepting edge, and the single result word shows in the next cycle. A new
// item may be taken in every cycle, so throughput is one item per cycle.
// Read out: busy stays high while the chain rotates among its filled cells,
// one step a cycle; the head cell is sampled and registered each step, so
// count result words follow on consecutive cycles, the first once the read
// state and then the result register have been loaded, and the chain is
// back in order when busy drops. A read out thus holds off the next item
// until busy drops. An empty list gives one word with has_value clear. Bad
// positions and unknown kinds give status bad position, inserts into a full
// list give status full, and in both cases the list is left as it was.
// Reset clears the entry count and the control; cell contents are not reset
// and are never read before they are written.
`default_nettype none

module positional_list_insert_delete_unit #(
	parameter int LIST_DEPTH = pli_pkg::DEFAULT_LIST_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire pli_pkg::in_t item,
	output logic result_valid,
	output pli_pkg::out_t result
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	pli_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	pli_pkg::out_t result_q, result_d;
	logic result_valid_q, result_valid_d;
	pli_pkg::cell_cmd_t cmd;
	logic signed [pli_pkg::VALUE_W-1:0] cell_value [LIST_DEPTH];

	logic accept;
	logic read_last;
	int pos;
	int cnt;

	assign accept = start && (state_q == pli_pkg::ST_IDLE);
	assign read_last = (idx_q == count_q - CNT_W'(1));
	assign pos = int'(item.position);
	assign cnt = int'(count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pli_pkg::ST_IDLE: begin
				if (accept && item.kind == pli_pkg::KIND_READ && count_q != '0) begin
					state_d = pli_pkg::ST_READ;
				end
			end
			pli_pkg::ST_READ: begin
				if (read_last) begin
					state_d = pli_pkg::ST_IDLE;
				end
			end
			default: state_d = pli_pkg::ST_IDLE;
		endcase
	end

	// outputs, cell command and counters
	always_comb begin
		count_d = count_q;
		idx_d = idx_q;
		result_d = result_q;
		result_valid_d = 1'b0;
		cmd.op = pli_pkg::OP_HOLD;
		cmd.pos = item.position;
		cmd.value = item.value;
		unique case (state_q)
			pli_pkg::ST_IDLE: begin
				idx_d = '0;
				if (accept) begin
					result_valid_d = 1'b1;
					result_d.status = pli_pkg::STATUS_OK;
					result_d.entry_value = '0;
					result_d.has_value = 1'b0;
					result_d.last = 1'b1;
					case (item.kind)
						pli_pkg::KIND_INSERT: begin
							if (pos < 1 || pos > cnt + 1) begin
								result_d.status = pli_pkg::STATUS_BAD_POS;
							end else if (cnt >= LIST_DEPTH) begin
								result_d.status = pli_pkg::STATUS_FULL;
							end else begin
								cmd.op = pli_pkg::OP_INSERT;
								count_d = count_q + CNT_W'(1);
							end
						end
						pli_pkg::KIND_DELETE: begin
							if (pos < 1 || pos > cnt) begin
								result_d.status = pli_pkg::STATUS_BAD_POS;
							end else begin
								cmd.op = pli_pkg::OP_DELETE;
								count_d = count_q - CNT_W'(1);
							end
						end
						pli_pkg::KIND_READ: begin
							// non-empty read out is handled in the read state
							if (count_q != '0) begin
								result_valid_d = 1'b0;
							end
						end
						default: result_d.status = pli_pkg::STATUS_BAD_POS;
					endcase
					result_d.list_length = pli_pkg::LEN_W'(count_d);
				end
			end
			pli_pkg::ST_READ: begin
				// sample the head, then rotate the filled cells one place
				cmd.op = pli_pkg::OP_ROTATE;
				idx_d = idx_q + CNT_W'(1);
				result_valid_d = 1'b1;
				result_d.status = pli_pkg::STATUS_OK;
				result_d.entry_value = cell_value[0];
				result_d.has_value = 1'b1;
				result_d.list_length = pli_pkg::LEN_W'(count_q);
				result_d.last = read_last;
			end
			default: begin
				result_valid_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pli_pkg::ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q <= idx_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	genvar i;
	generate
		for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
			logic signed [pli_pkg::VALUE_W-1:0] up_in;
			logic signed [pli_pkg::VALUE_W-1:0] next_in;
			logic signed [pli_pkg::VALUE_W-1:0] down_in;

			if (i == 0) begin : g_head
				assign up_in = cell_value[i];
			end else begin : g_body
				assign up_in = cell_value[i-1];
			end

			if (i == LIST_DEPTH - 1) begin : g_tail
				assign next_in = cell_value[i];
			end else begin : g_mid
				assign next_in = cell_value[i+1];
			end

			// the last filled cell takes the head value for rotation
			assign down_in = (i == cnt - 1) ? cell_value[0] : next_in;

			pli_cell #(
				.INDEX(i)
			) u_cell (
				.clk(clk),
				.cmd(cmd),
				.up_value(up_in),
				.down_value(down_in),
				.value(cell_value[i])
			);
		end
	endgenerate

	assign busy = (state_q == pli_pkg::ST_READ);
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire
